// ===== sv/btp_pkg.sv =====
package btp_pkg;

    typedef enum logic [2:0] {
        REG_IMAGE_WIDTH     = 3'd0,
        REG_IMAGE_HEIGHT    = 3'd1,
        REG_BRICKS_ACROSS   = 3'd2,
        REG_BRICKS_DOWN     = 3'd3,
        REG_MORTAR_PERMILLE = 3'd4,
        REG_VAR_PERMILLE    = 3'd5
    } btp_reg_t;

    typedef struct packed {
        logic [7:0] col;
        logic [6:0] row;
        logic       mortar;
    } btp_cell_t;

    localparam logic [31:0] HASH_COL   = 32'd374761393;
    localparam logic [31:0] HASH_ROW   = 32'd668265263;
    localparam logic [31:0] HASH_MIX   = 32'd1274126177;

    localparam logic [8:0]  MORTAR_MAX = 9'd490;
    localparam logic [7:0]  MORTAR_GRAY = 8'd204;

    localparam logic [7:0]  BRICK_A_R = 8'd161;
    localparam logic [7:0]  BRICK_A_G = 8'd54;
    localparam logic [7:0]  BRICK_A_B = 8'd41;
    localparam logic [7:0]  BRICK_B_R = 8'd140;
    localparam logic [7:0]  BRICK_B_G = 8'd46;
    localparam logic [7:0]  BRICK_B_B = 8'd31;

    // t16 accumulator: 32768*500 midpoint, 65536*500 ceiling
    localparam logic signed [27:0] ACC_MID = 28'sd16384000;
    localparam logic [25:0] ACC_TOP    = 26'd32768000;
    localparam logic [25:0] ACC_ROUND  = 26'd250;
    localparam logic [26:0] RECIP_500  = 27'd68719476;    // floor(2^35/500)
    localparam int          RECIP_SHIFT = 35;
    localparam logic [9:0]  DIV_500    = 10'd500;

    localparam logic [20:0] SHADE_BASE = 21'd917504;
    localparam logic [27:0] SHADE_RND  = 28'd655360;
    localparam logic [7:0]  RECIP_5    = 8'd205;           // x/5 == (x*205)>>10, x<1024

    localparam int          CFG_W      = 13;

endpackage

// ===== sv/btp_div.sv =====
module btp_div #(
    parameter int NUM_W = 13,
    parameter int DEN_W = 14,
    parameter int QUO_W = 12,
    parameter int SB_W  = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    input  logic [SB_W-1:0]  sb,
    output logic             out_valid,
    output logic [QUO_W-1:0] quo,
    output logic [DEN_W-1:0] rem,
    output logic [SB_W-1:0]  sb_out
);
    import btp_pkg::*;

    // one quotient bit per stage, restoring
    localparam int CW = NUM_W + DEN_W + QUO_W;

    logic             vld_reg [QUO_W];
    logic [NUM_W-1:0] rem_reg [QUO_W];
    logic [QUO_W-1:0] quo_reg [QUO_W];
    logic [SB_W-1:0]  sb_reg  [QUO_W];

    for (genvar k = 0; k < QUO_W; k++)
    begin : g_stage
        logic             vld_in;
        logic [NUM_W-1:0] rem_in;
        logic [QUO_W-1:0] quo_in;
        logic [SB_W-1:0]  sb_in;
        logic [CW-1:0]    sub;
        logic [CW-1:0]    diff;
        logic             fits;

        if (k == 0)
        begin : g_first
            assign vld_in = in_valid;
            assign rem_in = num;
            assign quo_in = '0;
            assign sb_in  = sb;
        end
        else
        begin : g_next
            assign vld_in = vld_reg[k-1];
            assign rem_in = rem_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign sb_in  = sb_reg[k-1];
        end

        assign sub  = CW'(den) << (QUO_W - 1 - k);
        assign fits = CW'(rem_in) >= sub;
        assign diff = CW'(rem_in) - sub;

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[k] <= 1'b0;
            end
            else
            begin
                vld_reg[k] <= vld_in;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[k] <= fits ? diff[NUM_W-1:0] : rem_in;
            quo_reg[k] <= {quo_in[QUO_W-2:0], fits};
            sb_reg[k]  <= sb_in;
        end
    end

    assign out_valid = vld_reg[QUO_W-1];
    assign quo       = quo_reg[QUO_W-1];
    assign rem       = DEN_W'(rem_reg[QUO_W-1]);
    assign sb_out    = sb_reg[QUO_W-1];

endmodule

// ===== sv/btp_shade.sv =====
module btp_shade (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  btp_pkg::btp_cell_t brick,
    input  logic [9:0]        variation,
    output logic              out_valid,
    output logic [7:0]        red,
    output logic [7:0]        green,
    output logic [7:0]        blue,
    output logic              is_mortar
);
    import btp_pkg::*;

    localparam int NST = 6;

    logic       vld_reg    [NST];
    logic       mortar_reg [NST];
    logic       use_a_reg  [NST];

    logic [31:0] h1_reg, h2_reg;
    logic signed [27:0] acc_reg;
    logic [16:0] qe_reg;
    logic [25:0] n_reg;
    logic [16:0] t16_reg;
    logic [9:0]  nr_reg, ng_reg, nb_reg;

    logic [31:0] h1_next, h2_next, hv;
    logic [15:0] s16;
    logic signed [27:0] s_ext, v_ext, acc_next;
    logic [25:0] clamped, n_next;
    logic [52:0] prod;
    logic [16:0] qe_next;
    logic [25:0] r;
    logic [16:0] t16_next;
    logic [20:0] k_mul;
    logic [7:0]  base_r, base_g, base_b;
    logic [27:0] cr, cg, cb;
    logic [17:0] pr, pg, pb;

    always_comb
    begin
        h1_next  = {24'b0, brick.col} * HASH_COL + {25'b0, brick.row} * HASH_ROW;
        h2_next  = (h1_reg ^ (h1_reg >> 13)) * HASH_MIX;
        hv       = h2_reg ^ (h2_reg >> 16);
        s16      = {~hv[31], hv[30:16]};
        s_ext    = {{12{s16[15]}}, s16};
        v_ext    = {18'b0, variation};
        acc_next = ACC_MID + s_ext * v_ext;
        if (acc_reg[27])
        begin
            clamped = '0;
        end
        else if (acc_reg[25:0] > ACC_TOP || acc_reg[26])
        begin
            clamped = ACC_TOP;
        end
        else
        begin
            clamped = acc_reg[25:0];
        end
        n_next   = clamped + ACC_ROUND;
        prod     = {27'b0, n_next} * {26'b0, RECIP_500};
        qe_next  = prod[RECIP_SHIFT +: 17];
        r        = n_reg - 26'(qe_reg * 26'(DIV_500));
        t16_next = (r >= 26'(DIV_500)) ? qe_reg + 17'd1 : qe_reg;
        k_mul    = SHADE_BASE + 21'(t16_reg) * 21'd10;
        base_r   = use_a_reg[4] ? BRICK_A_R : BRICK_B_R;
        base_g   = use_a_reg[4] ? BRICK_A_G : BRICK_B_G;
        base_b   = use_a_reg[4] ? BRICK_A_B : BRICK_B_B;
        cr       = 28'(base_r) * 28'(k_mul) + SHADE_RND;
        cg       = 28'(base_g) * 28'(k_mul) + SHADE_RND;
        cb       = 28'(base_b) * 28'(k_mul) + SHADE_RND;
        pr       = 18'(nr_reg) * 18'(RECIP_5);
        pg       = 18'(ng_reg) * 18'(RECIP_5);
        pb       = 18'(nb_reg) * 18'(RECIP_5);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NST; i++)
            begin
                vld_reg[i] <= 1'b0;
            end
            out_valid <= 1'b0;
        end
        else
        begin
            vld_reg[0] <= in_valid;
            for (int i = 1; i < NST; i++)
            begin
                vld_reg[i] <= vld_reg[i-1];
            end
            out_valid <= vld_reg[NST-1];
        end
    end

    always_ff @(posedge clk)
    begin
        mortar_reg[0] <= brick.mortar;
        use_a_reg[0]  <= ~(brick.row[0] ^ brick.col[0]);
        for (int i = 1; i < NST; i++)
        begin
            mortar_reg[i] <= mortar_reg[i-1];
            use_a_reg[i]  <= use_a_reg[i-1];
        end
        h1_reg  <= h1_next;
        h2_reg  <= h2_next;
        acc_reg <= acc_next;
        qe_reg  <= qe_next;
        n_reg   <= n_next;
        t16_reg <= t16_next;
        nr_reg  <= cr[27:18];
        ng_reg  <= cg[27:18];
        nb_reg  <= cb[27:18];
        red       <= mortar_reg[NST-1] ? MORTAR_GRAY : pr[17:10];
        green     <= mortar_reg[NST-1] ? MORTAR_GRAY : pg[17:10];
        blue      <= mortar_reg[NST-1] ? MORTAR_GRAY : pb[17:10];
        is_mortar <= mortar_reg[NST-1];
    end

endmodule

// ===== sv/brick_texture_pixel_core.sv =====
// Brick-wall texture generator, one pixel per clock.
// Requests: pixel_x/pixel_y are taken at a rising edge with start high and
// busy low. busy is always low, so a request can be issued every cycle.
// Only the low COORD_BITS bits of each coordinate are used.
// Results: red/green/blue/is_mortar are valid for the single cycle in which
// done is high; they arrive in request order. Throughput is one pixel per
// clock; the pipeline includes four bit-per-stage dividers (two coordinate
// wraps of COORD_BITS stages, row of 7 and column of 8).
// The receiver cannot stall; nothing is held back.
// Configuration: cfg_valid/cfg_index/cfg_data write a register when
// cfg_ready is high (always). Indices: 0 width, 1 height, 2 bricks across,
// 3 bricks down, 4 mortar permille, 5 variation permille. Write only when
// no request is in flight.
// Reset: clears the pipeline valid bits and loads default registers
// (256x256 image, 10x6 bricks, mortar 70, variation 120).
module brick_texture_pixel_core #(
    parameter int COORD_BITS = 12
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [btp_pkg::CFG_W-1:0] cfg_data,
    output logic        done,
    output logic [7:0]  red,
    output logic [7:0]  green,
    output logic [7:0]  blue,
    output logic        is_mortar
);
    import btp_pkg::*;

    localparam int CB  = COORD_BITS;
    localparam int LAT = 2 * CB + 26;

    logic [12:0] width_reg, height_reg;
    logic [6:0]  across_reg, down_reg;
    logic [8:0]  mortar_reg;
    logic [9:0]  var_reg;

    logic [12:0] w_eff, h_eff;
    logic [13:0] dx, dy;
    logic [8:0]  mp;
    logic        req;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign req       = start & ~busy;
    assign w_eff     = (width_reg == '0) ? 13'd1 : width_reg;
    assign h_eff     = (height_reg == '0) ? 13'd1 : height_reg;
    assign dx        = {w_eff, 1'b0};
    assign dy        = {h_eff, 1'b0};
    assign mp        = (mortar_reg > MORTAR_MAX) ? MORTAR_MAX : mortar_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= 13'd256;
            height_reg <= 13'd256;
            across_reg <= 7'd10;
            down_reg   <= 7'd6;
            mortar_reg <= 9'd70;
            var_reg    <= 10'd120;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (btp_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:     width_reg  <= cfg_data;
                REG_IMAGE_HEIGHT:    height_reg <= cfg_data;
                REG_BRICKS_ACROSS:   across_reg <= cfg_data[6:0];
                REG_BRICKS_DOWN:     down_reg   <= cfg_data[6:0];
                REG_MORTAR_PERMILLE: mortar_reg <= cfg_data[8:0];
                REG_VAR_PERMILLE:    var_reg    <= cfg_data[9:0];
                default: ;
            endcase
        end
    end

    // y wrap, x carried alongside
    logic [CB-1:0] px, py, xa;
    logic          va;
    logic [13:0]   ay;
    assign px = CB'(pixel_x);
    assign py = CB'(pixel_y);

    btp_div #(.NUM_W(CB + 1), .DEN_W(14), .QUO_W(CB), .SB_W(CB)) u_ymod (
        .clk(clk), .rst_n(rst_n), .in_valid(req),
        .num({py, 1'b1}), .den(dy), .sb(px),
        .out_valid(va), .quo(), .rem(ay), .sb_out(xa)
    );

    // x wrap
    logic        vb;
    logic [13:0] ax, ayb;

    btp_div #(.NUM_W(CB + 1), .DEN_W(14), .QUO_W(CB), .SB_W(14)) u_xmod (
        .clk(clk), .rst_n(rst_n), .in_valid(va),
        .num({xa, 1'b1}), .den(dx), .sb(ay),
        .out_valid(vb), .quo(), .rem(ax), .sb_out(ayb)
    );

    logic        vc_reg;
    logic [20:0] ny_reg;
    logic [13:0] axc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vc_reg <= 1'b0;
        end
        else
        begin
            vc_reg <= vb;
        end
    end

    always_ff @(posedge clk)
    begin
        ny_reg  <= 21'(ayb) * 21'(down_reg);
        axc_reg <= ax;
    end

    // row
    logic        vd;
    logic [6:0]  row_d;
    logic [13:0] remy_d, axd;

    btp_div #(.NUM_W(21), .DEN_W(14), .QUO_W(7), .SB_W(14)) u_row (
        .clk(clk), .rst_n(rst_n), .in_valid(vc_reg),
        .num(ny_reg), .den(dy), .sb(axc_reg),
        .out_valid(vd), .quo(row_d), .rem(remy_d), .sb_out(axd)
    );

    logic        ve_reg;
    logic [21:0] nx_reg;
    logic [6:0]  row_e_reg;
    logic [13:0] remy_e_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ve_reg <= 1'b0;
        end
        else
        begin
            ve_reg <= vd;
        end
    end

    always_ff @(posedge clk)
    begin
        nx_reg     <= 22'(axd) * 22'(across_reg) + (row_d[0] ? 22'(w_eff) : 22'd0);
        row_e_reg  <= row_d;
        remy_e_reg <= remy_d;
    end

    // column
    logic        vf;
    logic [7:0]  col_f;
    logic [13:0] remx_f, remy_f;
    logic [6:0]  row_f;

    btp_div #(.NUM_W(22), .DEN_W(14), .QUO_W(8), .SB_W(21)) u_col (
        .clk(clk), .rst_n(rst_n), .in_valid(ve_reg),
        .num(nx_reg), .den(dx), .sb({row_e_reg, remy_e_reg}),
        .out_valid(vf), .quo(col_f), .rem(remx_f), .sb_out({row_f, remy_f})
    );

    // distance to nearest cell edge, then mortar test
    logic        vg_reg, vh_reg;
    logic [13:0] dmx_reg, dmy_reg;
    logic [7:0]  col_g_reg;
    logic [6:0]  row_g_reg;
    logic [13:0] ox, oy;
    btp_cell_t   cell_reg;
    logic [23:0] lhs_x, lhs_y, rhs_x, rhs_y;

    assign ox    = dx - remx_f;
    assign oy    = dy - remy_f;
    assign lhs_x = 24'(dmx_reg) * 24'd1000;
    assign lhs_y = 24'(dmy_reg) * 24'd1000;
    assign rhs_x = 24'(mp) * 24'(dx);
    assign rhs_y = 24'(mp) * 24'(dy);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vg_reg <= 1'b0;
            vh_reg <= 1'b0;
        end
        else
        begin
            vg_reg <= vf;
            vh_reg <= vg_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        dmx_reg   <= (remx_f < ox) ? remx_f : ox;
        dmy_reg   <= (remy_f < oy) ? remy_f : oy;
        col_g_reg <= col_f;
        row_g_reg <= row_f;
        cell_reg.col    <= col_g_reg;
        cell_reg.row    <= row_g_reg;
        cell_reg.mortar <= (lhs_x < rhs_x) || (lhs_y < rhs_y);
    end

    btp_shade u_shade (
        .clk(clk), .rst_n(rst_n), .in_valid(vh_reg),
        .brick(cell_reg), .variation(var_reg),
        .out_valid(done), .red(red), .green(green), .blue(blue),
        .is_mortar(is_mortar)
    );

`ifndef SYNTHESIS
    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(req, LAT))
        else $error("result without matching request");

    a_mortar_gray: assert property (@(posedge clk) disable iff (!rst_n)
        (done && is_mortar) |->
            (red == MORTAR_GRAY && green == MORTAR_GRAY && blue == MORTAR_GRAY))
        else $error("mortar pixel not gray");

    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        req |-> ##LAT done)
        else $error("request lost in pipeline");
`endif

endmodule

// ===== dv/brick_checker.sv =====
module brick_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic        busy,
    input  logic [11:0] pixel_x,
    input  logic [11:0] pixel_y,
    input  logic        cfg_valid,
    input  logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [btp_pkg::CFG_W-1:0] cfg_data,
    input  logic        done,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic        is_mortar,
    output int          errors,
    output int          pending
);
    timeunit 1ns;
    timeprecision 1ps;
    import btp_pkg::*;

    typedef struct packed {
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        logic       m;
    } pixel_rgb_t;

    logic [12:0] width_q, height_q;
    logic [6:0]  across_q, down_q;
    logic [8:0]  mortar_q;
    logic [9:0]  var_q;

    pixel_rgb_t colour_q[$];

    function automatic logic [31:0] cell_hash(logic [31:0] col, logic [31:0] row);
        logic [31:0] h;
        h = col * HASH_COL + row * HASH_ROW;
        h = (h ^ (h >> 13)) * HASH_MIX;
        h = h ^ (h >> 16);
        return h;
    endfunction

    function automatic bit in_mortar(longint unsigned rem, longint unsigned den,
                                     longint unsigned mp);
        longint unsigned other, d;
        other = den - rem;
        d = rem < other ? rem : other;
        return d * 1000 < mp * den;
    endfunction

    function automatic logic [7:0] shade(longint unsigned base, longint unsigned t16);
        longint unsigned num;
        num = base * (917504 + 10 * t16);
        return 8'((num + 655360) / 1310720);
    endfunction

    function automatic pixel_rgb_t brick_pixel_colour(logic [11:0] px, logic [11:0] py);
        longint unsigned x, y, w, h, dx, dy, ny, row, remy, nx, col, remx, mp, t16;
        longint acc, s;
        logic [31:0] hv;
        bit use_a;
        pixel_rgb_t res;
        x = px;
        y = py;
        w = width_q != 0 ? width_q : 1;
        h = height_q != 0 ? height_q : 1;
        dx = 2 * w;
        dy = 2 * h;
        ny = ((2 * y + 1) % dy) * down_q;
        row = ny / dy;
        remy = ny % dy;
        nx = ((2 * x + 1) % dx) * across_q + (row[0] ? w : 0);
        col = nx / dx;
        remx = nx % dx;
        mp = mortar_q > MORTAR_MAX ? MORTAR_MAX : mortar_q;
        if (in_mortar(remx, dx, mp) || in_mortar(remy, dy, mp))
        begin
            res = '{MORTAR_GRAY, MORTAR_GRAY, MORTAR_GRAY, 1'b1};
            return res;
        end
        use_a = ((row ^ col) & 1) == 0;
        hv = cell_hash(32'(col), 32'(row));
        s = longint'(hv[31:16]) - 32768;
        acc = 32768 * 500 + s * longint'(var_q);
        if (acc < 0)
            acc = 0;
        if (acc > 65536 * 500)
            acc = 65536 * 500;
        t16 = (acc + 250) / 500;
        res.r = shade(use_a ? BRICK_A_R : BRICK_B_R, t16);
        res.g = shade(use_a ? BRICK_A_G : BRICK_B_G, t16);
        res.b = shade(use_a ? BRICK_A_B : BRICK_B_B, t16);
        res.m = 1'b0;
        return res;
    endfunction

    assign pending = colour_q.size();

    always @(posedge clk or negedge rst_n)
    begin
        pixel_rgb_t want, got;
        if (!rst_n)
        begin
            width_q  <= 13'd256;
            height_q <= 13'd256;
            across_q <= 7'd10;
            down_q   <= 7'd6;
            mortar_q <= 9'd70;
            var_q    <= 10'd120;
            colour_q.delete();
            errors   <= 0;
        end
        else
        begin
            if (done)
            begin
                got = '{red, green, blue, is_mortar};
                if (colour_q.size() == 0)
                begin
                    if (errors < 10)
                        $display("unexpected result r=%0d g=%0d b=%0d m=%0d",
                                 red, green, blue, is_mortar);
                    errors <= errors + 1;
                end
                else
                begin
                    want = colour_q.pop_front();
                    if (got !== want)
                    begin
                        if (errors < 10)
                            $display("mismatch exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                                     want.r, want.g, want.b, want.m,
                                     red, green, blue, is_mortar);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                colour_q.push_back(brick_pixel_colour(pixel_x, pixel_y));
            if (cfg_valid && cfg_ready)
            begin
                case (btp_reg_t'(cfg_index))
                    REG_IMAGE_WIDTH:     width_q  <= cfg_data;
                    REG_IMAGE_HEIGHT:    height_q <= cfg_data;
                    REG_BRICKS_ACROSS:   across_q <= cfg_data[6:0];
                    REG_BRICKS_DOWN:     down_q   <= cfg_data[6:0];
                    REG_MORTAR_PERMILLE: mortar_q <= cfg_data[8:0];
                    REG_VAR_PERMILLE:    var_q    <= cfg_data[9:0];
                    default: ;
                endcase
            end
        end
    end
endmodule

// ===== dv/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;
    import btp_pkg::*;

    localparam int LATENCY = 60;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    logic        busy;
    logic [11:0] pixel_x = '0;
    logic [11:0] pixel_y = '0;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic        done;
    logic [7:0]  red, green, blue;
    logic        is_mortar;
    int          errors, pending;

    int unsigned cur_w = 256, cur_h = 256;
    bit          allow_idle = 1'b1;

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    brick_texture_pixel_core dut (.*);

    brick_checker chk (.*);

    initial
    begin
        #2000000;
        $display("FAIL brick_texture_pixel_core");
        $finish;
    end

    task automatic write_reg(btp_reg_t idx, int unsigned val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= CFG_W'(val);
        do @(posedge clk); while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
        if (idx == REG_IMAGE_WIDTH)
            cur_w = (val & 13'h1FFF) == 0 ? 1 : (val & 13'h1FFF);
        if (idx == REG_IMAGE_HEIGHT)
            cur_h = (val & 13'h1FFF) == 0 ? 1 : (val & 13'h1FFF);
    endtask

    task automatic send_pixel(logic [11:0] x, logic [11:0] y);
        @(negedge clk);
        start   <= 1'b1;
        pixel_x <= x;
        pixel_y <= y;
        do @(posedge clk); while (busy);
        if (allow_idle && $urandom_range(0, 5) == 0)
        begin
            repeat ($urandom_range(1, 14))
            begin
                @(negedge clk);
                start <= 1'b0;
            end
        end
    endtask

    task automatic drain();
        @(negedge clk);
        start <= 1'b0;
        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
    endtask

    function automatic int unsigned pick_size();
        case ($urandom_range(0, 9))
            0:       return 0;
            1:       return $urandom_range(1, 8191);
            2, 3:    return $urandom_range(1, 4096);
            default: return $urandom_range(1, 64);
        endcase
    endfunction

    function automatic logic [11:0] pick_coord(int unsigned lim);
        if ($urandom_range(0, 4) == 0 || lim > 4096)
            return 12'($urandom);
        return 12'($urandom_range(0, lim - 1));
    endfunction

    initial
    begin
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // default settings, corners of the image and of the field range
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd255, 12'd255);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd4095, 12'd0);
        send_pixel(12'd128, 12'd21);
        drain();

        // zero sizes and zero bricks, mortar zero
        write_reg(REG_IMAGE_WIDTH, 0);
        write_reg(REG_IMAGE_HEIGHT, 0);
        write_reg(REG_BRICKS_ACROSS, 0);
        write_reg(REG_BRICKS_DOWN, 0);
        write_reg(REG_MORTAR_PERMILLE, 0);
        write_reg(REG_VAR_PERMILLE, 0);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        drain();

        // widest mortar beyond the clamp, saturating variation, largest sizes
        write_reg(REG_IMAGE_WIDTH, 8191);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_BRICKS_ACROSS, 127);
        write_reg(REG_BRICKS_DOWN, 127);
        write_reg(REG_MORTAR_PERMILLE, 511);
        write_reg(REG_VAR_PERMILLE, 1023);
        send_pixel(12'd0, 12'd0);
        send_pixel(12'd4095, 12'd4095);
        send_pixel(12'd2048, 12'd1000);
        drain();

        write_reg(REG_IMAGE_WIDTH, 64);
        write_reg(REG_IMAGE_HEIGHT, 64);
        write_reg(REG_BRICKS_ACROSS, 64);
        write_reg(REG_BRICKS_DOWN, 64);
        write_reg(REG_MORTAR_PERMILLE, 490);
        write_reg(REG_VAR_PERMILLE, 1000);
        send_pixel(12'd0, 12'd1);
        send_pixel(12'd63, 12'd63);
        send_pixel(12'd17, 12'd40);
        send_pixel(12'd100, 12'd200);
        drain();

        write_reg(REG_IMAGE_WIDTH, 1);
        write_reg(REG_IMAGE_HEIGHT, 4096);
        write_reg(REG_BRICKS_ACROSS, 1);
        write_reg(REG_BRICKS_DOWN, 1);
        write_reg(REG_MORTAR_PERMILLE, 0);
        write_reg(REG_VAR_PERMILLE, 1023);
        send_pixel(12'd0, 12'd2048);
        send_pixel(12'd0, 12'd4095);
        drain();

        for (int ph = 0; ph < 15; ph++)
        begin
            write_reg(REG_IMAGE_WIDTH, pick_size());
            write_reg(REG_IMAGE_HEIGHT, pick_size());
            write_reg(REG_BRICKS_ACROSS, $urandom_range(0, 9) == 0
                      ? $urandom_range(0, 127) : $urandom_range(1, 64));
            write_reg(REG_BRICKS_DOWN, $urandom_range(0, 9) == 0
                      ? $urandom_range(0, 127) : $urandom_range(1, 64));
            write_reg(REG_MORTAR_PERMILLE, $urandom_range(0, 5) == 0
                      ? $urandom_range(0, 511) : $urandom_range(0, 150));
            write_reg(REG_VAR_PERMILLE, $urandom_range(0, 1023));
            allow_idle = (ph < 12);
            for (int i = 0; i < 70; i++)
            begin
                send_pixel(pick_coord(cur_w), pick_coord(cur_h));
                if (ph == 3 && i == 35)
                begin
                    @(negedge clk);
                    start <= 1'b0;
                    while (pending != 0)
                        @(posedge clk);
                end
            end
            drain();
        end

        if (errors == 0)
            $display("PASS brick_texture_pixel_core");
        else
            $display("FAIL brick_texture_pixel_core");
        $finish;
    end
endmodule

// ===== brick_texture_pixel_core.f =====
sv/btp_pkg.sv
sv/btp_div.sv
sv/btp_shade.sv
sv/brick_texture_pixel_core.sv
dv/brick_checker.sv
dv/tb_top.sv
